// ===== hw/rtl/ist_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ist_pkg: shared types and constants of the integer set table
// Operation codes, command and result words, cell control and tree nodes.
// ----------------------------------------------------------------------------
package ist_pkg;

	localparam int DEPTH  = 16;
	localparam int LG     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int LEAVES = 1 << LG;
	localparam int CNT_W  = $clog2(DEPTH + 1);

	localparam logic [1:0] OP_CLEAR  = 2'd0;
	localparam logic [1:0] OP_INSERT = 2'd1;
	localparam logic [1:0] OP_REMOVE = 2'd2;
	localparam logic [1:0] OP_QUERY  = 2'd3;

	typedef struct packed {
		logic [1:0]         operation;
		logic signed [31:0] value;
	} in_t;

	typedef struct packed {
		logic               was_member;
		logic               dropped;
		logic [4:0]         entry_count;
		logic               is_empty;
		logic signed [31:0] smallest;
		logic signed [31:0] largest;
	} out_t;

	// broadcast to every cell in the accept cycle
	typedef struct packed {
		logic clear;
		logic ins;
		logic rem;
	} cell_ctl_t;

	// flags that travel beside the min/max tree
	typedef struct packed {
		logic             was_member;
		logic             dropped;
		logic [CNT_W-1:0] count;
	} side_t;

	typedef struct packed {
		logic               valid;
		logic signed [31:0] lo;
		logic signed [31:0] hi;
	} node_t;

	// combine two subtrees; an invalid side drops out
	function automatic node_t merge(node_t a, node_t b);
		node_t r;
		if (!a.valid) begin
			r = b;
		end else if (!b.valid) begin
			r = a;
		end else begin
			r.valid = 1'b1;
			r.lo    = (b.lo < a.lo) ? b.lo : a.lo;
			r.hi    = (b.hi > a.hi) ? b.hi : a.hi;
		end
		return r;
	endfunction

endpackage

// ===== hw/rtl/integer_set_table.sv =====
`timescale 1ns / 1ps
// done is high for a command taken on start after the cell update register and then
// one register stage per level of the min/max tree.
// Throughput: one word per cycle; the cells update at the accept edge, so busy stays low.
// Reset clears every valid bit and the count; the result port never stalls.
// ----------------------------------------------------------------------------
// integer_set_table: bounded set of distinct signed values in insertion order
// A row of cells holds the entries, compares in parallel and shifts to close
// gaps; a registered tree reports the minimum and maximum afterward.
// ----------------------------------------------------------------------------
module integer_set_table (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  ist_pkg::in_t    cmd,
	output logic            done,
	output ist_pkg::out_t   res
);

	localparam int N = ist_pkg::DEPTH;

	logic signed [31:0]      elem_w [N+1];
	logic [N:0]              valid_ext;
	logic [N:0]              left_ext;
	logic [N:0]              hit_w;
	logic [N-1:0]            valid_w;
	logic [ist_pkg::CNT_W-1:0] count_q;
	logic [ist_pkg::CNT_W-1:0] count_next;
	logic                    accept;
	logic                    present;
	logic                    full;
	logic                    drop;
	ist_pkg::cell_ctl_t      ctl;
	ist_pkg::side_t          side;
	ist_pkg::side_t          out_side;
	ist_pkg::node_t          leaves [ist_pkg::LEAVES];
	ist_pkg::node_t          root;

	assign busy    = 1'b0;
	assign accept  = start & ~busy;
	assign present = hit_w[N];
	assign full    = valid_w[N-1];

	// neighbor wiring: a virtual full cell on the left, an empty one on the right
	assign left_ext  = {valid_w, 1'b1};
	assign valid_ext = {1'b0, valid_w};
	assign elem_w[N] = '0;
	assign hit_w[0]  = 1'b0;

	// broadcast the operation to the row
	always_comb begin
		ctl.clear = accept && (cmd.operation == ist_pkg::OP_CLEAR);
		ctl.ins   = accept && (cmd.operation == ist_pkg::OP_INSERT) && !present && !full;
		ctl.rem   = accept && (cmd.operation == ist_pkg::OP_REMOVE) && present;
		drop      = (cmd.operation == ist_pkg::OP_INSERT) && !present && full;
	end

	for (genvar i = 0; i < N; i++) begin : g_cell
		ist_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (ctl),
			.value       (cmd.value),
			.left_valid  (left_ext[i]),
			.right_elem  (elem_w[i+1]),
			.right_valid (valid_ext[i+1]),
			.hit_in      (hit_w[i]),
			.elem        (elem_w[i]),
			.valid       (valid_w[i]),
			.hit_out     (hit_w[i+1])
		);
	end

	// next entry count
	always_comb begin
		count_next = count_q;
		unique case (cmd.operation)
			ist_pkg::OP_CLEAR:  count_next = '0;
			ist_pkg::OP_INSERT: if (!present && !full) count_next = count_q + 1'b1;
			ist_pkg::OP_REMOVE: if (present) count_next = count_q - 1'b1;
			ist_pkg::OP_QUERY:  count_next = count_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			count_q <= count_next;
		end
	end

	// flags for the result word
	always_comb begin
		side.was_member = present;
		side.dropped    = drop;
		side.count      = count_next;
	end

	// tree leaves, padded with empty nodes
	always_comb begin
		for (int i = 0; i < ist_pkg::LEAVES; i++) begin
			leaves[i] = '0;
		end
		for (int i = 0; i < N; i++) begin
			leaves[i].valid = valid_w[i];
			leaves[i].lo    = elem_w[i];
			leaves[i].hi    = elem_w[i];
		end
	end

	ist_minmax u_minmax (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (accept),
		.in_side   (side),
		.leaves    (leaves),
		.out_valid (done),
		.out_side  (out_side),
		.root      (root)
	);

	// form the result word
	always_comb begin
		res.was_member  = out_side.was_member;
		res.dropped     = out_side.dropped;
		res.entry_count = 5'(out_side.count);
		res.is_empty    = (out_side.count == '0);
		res.smallest    = root.valid ? root.lo : 32'sd0;
		res.largest     = root.valid ? root.hi : 32'sd0;
	end

	a_count_matches_valid: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_w) == int'(count_q))
		else $error("count register disagrees with cell valid bits");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.ins |=> count_q == $past(count_q) + 1'b1)
		else $error("insert of a new value did not grow the table");

	a_drop_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		done && res.dropped |-> !res.was_member && (out_side.count == ist_pkg::CNT_W'(N)))
		else $error("drop reported on a table that was not full");

	a_min_le_max: assert property (@(posedge clk) disable iff (!arst_n)
		done && !res.is_empty |-> res.smallest <= res.largest)
		else $error("minimum exceeds maximum");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && res.is_empty |-> res.smallest == 32'sd0 && res.largest == 32'sd0)
		else $error("empty set reports a nonzero extreme");

endmodule

// ===== hw/rtl/ist_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ist_cell: one entry of the set table
// Holds a value and its valid bit, compares against the broadcast value,
// takes a new value on insert and its right neighbor's entry on remove.
// ----------------------------------------------------------------------------
module ist_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  ist_pkg::cell_ctl_t  ctl,
	input  logic signed [31:0]  value,
	input  logic                left_valid,
	input  logic signed [31:0]  right_elem,
	input  logic                right_valid,
	input  logic                hit_in,
	output logic signed [31:0]  elem,
	output logic                valid,
	output logic                hit_out
);

	logic signed [31:0] elem_q;
	logic               valid_q;
	logic               match;
	logic               take_right;
	logic               fill;

	// compare and pass the hit along the row
	assign match      = valid_q && (elem_q == value);
	assign hit_out    = hit_in | match;
	assign take_right = ctl.rem & hit_out;
	assign fill       = ctl.ins & ~valid_q & left_valid;

	// valid bit: clear, fill the first free slot, or shift down
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.clear) begin
			valid_q <= 1'b0;
		end else if (fill) begin
			valid_q <= 1'b1;
		end else if (take_right) begin
			valid_q <= right_valid;
		end
	end

	// stored value
	always_ff @(posedge clk) begin
		if (fill) begin
			elem_q <= value;
		end else if (take_right) begin
			elem_q <= right_elem;
		end
	end

	assign elem  = elem_q;
	assign valid = valid_q;

endmodule

// ===== hw/rtl/ist_minmax.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ist_minmax: registered min/max reduction over the cell row
// One tree level per stage; the result flags ride alongside.
// ----------------------------------------------------------------------------
module ist_minmax (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  ist_pkg::side_t      in_side,
	input  ist_pkg::node_t      leaves [ist_pkg::LEAVES],
	output logic                out_valid,
	output ist_pkg::side_t      out_side,
	output ist_pkg::node_t      root
);

	ist_pkg::node_t tree_s [1:ist_pkg::LG][ist_pkg::LEAVES/2];
	ist_pkg::side_t side_s [0:ist_pkg::LG];
	logic [ist_pkg::LG:0] vld_s;

	// advance the stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[ist_pkg::LG-1:0], in_valid};
		end
	end

	// hold flags beside the tree; stage 0 lines up with the cell update
	always_ff @(posedge clk) begin
		side_s[0] <= in_side;
		for (int l = 1; l <= ist_pkg::LG; l++) begin
			side_s[l] <= side_s[l-1];
		end
	end

	// reduce pairs, one level per clock
	always_ff @(posedge clk) begin
		for (int j = 0; j < ist_pkg::LEAVES/2; j++) begin
			tree_s[1][j] <= ist_pkg::merge(leaves[2*j], leaves[2*j+1]);
		end
		for (int l = 2; l <= ist_pkg::LG; l++) begin
			for (int j = 0; j < ist_pkg::LEAVES/4; j++) begin
				tree_s[l][j] <= ist_pkg::merge(tree_s[l-1][2*j], tree_s[l-1][2*j+1]);
			end
			for (int j = ist_pkg::LEAVES/4; j < ist_pkg::LEAVES/2; j++) begin
				tree_s[l][j] <= tree_s[l-1][j];
			end
		end
	end

	assign out_valid = vld_s[ist_pkg::LG];
	assign out_side  = side_s[ist_pkg::LG];
	assign root      = tree_s[ist_pkg::LG][0];

endmodule
